@@ sv/lpcd_pkg.sv @@
// Package: shared types and constants of the length-prefixed command deframer
`timescale 1ns / 1ps
package lpcd_pkg;
	localparam int LENGTH_BYTES = 4;
	localparam int COUNT_WIDTH = 32;
	localparam int PFX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		PH_PREFIX  = 3'd0,
		PH_COMMAND = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_ERROR   = 3'd3,
		PH_ENDED   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		EV_BYTE    = 3'd0,
		EV_ACCEPT  = 3'd1,
		EV_REJECT  = 3'd2,
		EV_REFUSED = 3'd3,
		EV_ENDED   = 3'd4
	} event_t;

	localparam logic [3:0] CMD_OPTIONS = 4'd0;
	localparam logic [3:0] CMD_MACRO   = 4'd1;
	localparam logic [3:0] CMD_CONNECT = 4'd2;
	localparam logic [3:0] CMD_HELO    = 4'd3;
	localparam logic [3:0] CMD_MAIL    = 4'd4;
	localparam logic [3:0] CMD_RCPT    = 4'd5;
	localparam logic [3:0] CMD_HEADER  = 4'd6;
	localparam logic [3:0] CMD_EOH     = 4'd7;
	localparam logic [3:0] CMD_BODY    = 4'd8;
	localparam logic [3:0] CMD_EOM     = 4'd9;
	localparam logic [3:0] CMD_ABORT   = 4'd10;
	localparam logic [3:0] CMD_QUIT    = 4'd11;
	localparam logic [3:0] CMD_UNKNOWN = 4'd12;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_UNKNOWN    = 4'd1;
	localparam logic [3:0] ERR_CONTEXT    = 4'd2;
	localparam logic [3:0] ERR_HOST       = 4'd3;
	localparam logic [3:0] ERR_FAMILY     = 4'd4;
	localparam logic [3:0] ERR_PORT       = 4'd5;
	localparam logic [3:0] ERR_NO_TERM    = 4'd6;
	localparam logic [3:0] ERR_HELO       = 4'd7;
	localparam logic [3:0] ERR_HEADER     = 4'd10;
	localparam logic [3:0] ERR_TOO_LONG   = 4'd11;
	localparam logic [3:0] ERR_INVALID    = 4'd12;
	localparam logic [3:0] ERR_ZERO_LEN   = 4'd13;
	localparam logic [3:0] ERR_ENDED      = 4'd14;

	// connect parser steps
	localparam logic [2:0] CS_HOST   = 3'd0;
	localparam logic [2:0] CS_FAMILY = 3'd1;
	localparam logic [2:0] CS_PORTHI = 3'd2;
	localparam logic [2:0] CS_PORTLO = 3'd3;
	localparam logic [2:0] CS_AFTER  = 3'd4;
	localparam logic [2:0] CS_DONE   = 3'd5;
	localparam logic [2:0] CS_UNIX   = 3'd6;

	// classified word handed from the front to the back
	typedef struct packed {
		logic       ended;      // end of stream
		logic       refused;    // refused input
		logic [3:0] ref_err;
		logic       zero_len;   // zero length prefix
		logic       first;      // command byte
		logic       last;       // last byte of frame
		logic       has;
		logic [7:0] data;
		logic [3:0] cmd;
		logic [COUNT_WIDTH-1:0] pos;
		logic       len_one;
	} work_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        has;
		logic [7:0]  data;
		logic [3:0]  cmd;
		logic [2:0]  ctx;
		logic [1:0]  fam;
		logic [15:0] port;
		logic [31:0] nlen;
		logic [3:0]  err;
	} result_t;

	function automatic logic [3:0] decode_command(input logic [7:0] b);
		logic [3:0] c;
		unique case (b)
			8'h4F: c = CMD_OPTIONS;
			8'h44: c = CMD_MACRO;
			8'h43: c = CMD_CONNECT;
			8'h48: c = CMD_HELO;
			8'h4D: c = CMD_MAIL;
			8'h52: c = CMD_RCPT;
			8'h4C: c = CMD_HEADER;
			8'h4E: c = CMD_EOH;
			8'h42: c = CMD_BODY;
			8'h45: c = CMD_EOM;
			8'h41: c = CMD_ABORT;
			8'h51: c = CMD_QUIT;
			default: c = CMD_UNKNOWN;
		endcase
		return c;
	endfunction

	// context letter: bit 3 set when valid
	function automatic logic [3:0] decode_context(input logic [7:0] b);
		logic [3:0] c;
		unique case (b)
			8'h43: c = 4'b1000;
			8'h48: c = 4'b1001;
			8'h4D: c = 4'b1010;
			8'h52: c = 4'b1011;
			8'h4C: c = 4'b1100;
			8'h4E: c = 4'b1101;
			8'h42: c = 4'b1110;
			8'h45: c = 4'b1111;
			default: c = 4'b0000;
		endcase
		return c;
	endfunction
endpackage

@@ sv/lpcd_front.sv @@
// Front end: length prefix collection, framing and word classification
`timescale 1ns / 1ps
module lpcd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 ready,
	input  logic [7:0]           data_byte,
	input  logic                 end_stream,
	output logic                 push,
	input  logic                 full,
	input  logic                 verdict_reject,
	output lpcd_pkg::work_t      work
);
	import lpcd_pkg::*;

	phase_t                 phase_q;
	logic [PFX_W-1:0]       pfx_q;
	logic [COUNT_WIDTH-1:0] len_q;
	logic [COUNT_WIDTH-1:0] left_q;
	logic [COUNT_WIDTH-1:0] pos_q;
	logic [3:0]             cmd_q;
	logic [COUNT_WIDTH-1:0] len_next;
	logic                   acc;

	assign ready = !full;
	assign acc = valid && ready;
	assign push = acc && !(phase_q == PH_PREFIX && !end_stream
		&& (int'(pfx_q) != LENGTH_BYTES - 1 || len_next != '0))
		&& !(phase_q == PH_COMMAND && !end_stream && len_q != COUNT_WIDTH'(1));

	if (COUNT_WIDTH > 8) begin : g_wide
		assign len_next = {len_q[COUNT_WIDTH-9:0], data_byte};
	end else begin : g_narrow
		assign len_next = data_byte[COUNT_WIDTH-1:0];
	end

	// classify the incoming word
	always_comb begin
		work = '0;
		work.data = data_byte;
		work.cmd = cmd_q;
		work.pos = pos_q;
		work.len_one = (len_q == COUNT_WIDTH'(1));
		if (end_stream) begin
			if (phase_q == PH_ENDED) begin
				work.refused = 1'b1;
				work.ref_err = ERR_ENDED;
			end else begin
				work.ended = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_PREFIX: work.zero_len = 1'b1;
				PH_COMMAND: begin
					work.first = 1'b1;
					work.last = 1'b1;
					work.cmd = decode_command(data_byte);
				end
				PH_PAYLOAD: begin
					work.has = 1'b1;
					work.last = (left_q == COUNT_WIDTH'(1));
				end
				PH_ERROR: begin
					work.refused = 1'b1;
					work.ref_err = ERR_INVALID;
				end
				default: begin
					work.refused = 1'b1;
					work.ref_err = ERR_ENDED;
				end
			endcase
		end
	end

	// framing state; the verdict tracker's predicted reject is taken here so the front never waits for the back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pfx_q <= '0;
			len_q <= '0;
			left_q <= '0;
			pos_q <= '0;
			cmd_q <= CMD_OPTIONS;
		end else if (acc) begin
			if (end_stream) begin
				phase_q <= PH_ENDED;
			end else begin
				unique case (phase_q)
					PH_PREFIX: begin
						len_q <= len_next;
						if (int'(pfx_q) != LENGTH_BYTES - 1) begin
							pfx_q <= pfx_q + 1'b1;
						end else begin
							pfx_q <= '0;
							phase_q <= (len_next == '0) ? PH_ERROR : PH_COMMAND;
						end
					end
					PH_COMMAND: begin
						cmd_q <= decode_command(data_byte);
						left_q <= len_q - 1'b1;
						pos_q <= '0;
						if (len_q == COUNT_WIDTH'(1)) begin
							phase_q <= verdict_reject ? PH_ERROR : PH_PREFIX;
							len_q <= '0;
						end else begin
							phase_q <= PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						left_q <= left_q - 1'b1;
						pos_q <= pos_q + 1'b1;
						if (left_q == COUNT_WIDTH'(1)) begin
							phase_q <= verdict_reject ? PH_ERROR : PH_PREFIX;
							len_q <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

@@ sv/lpcd_queue.sv @@
// Short queue of classified words between front and back
`timescale 1ns / 1ps
module lpcd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lpcd_pkg::work_t din,
	output logic            full,
	output logic            pop_valid,
	input  logic            pop,
	output lpcd_pkg::work_t dout
);
	import lpcd_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	work_t           mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW:0]     cnt_q;

	assign full = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

@@ sv/lpcd_back.sv @@
// Back end: per-command rule checks and result register
`timescale 1ns / 1ps
module lpcd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              pop,
	input  lpcd_pkg::work_t   work,
	output logic              out_valid,
	input  logic              out_ready,
	output lpcd_pkg::result_t res_q
);
	import lpcd_pkg::*;

	logic [2:0]  ctx_q;
	logic        ctx_ok_q;
	logic [2:0]  step_q;
	logic [1:0]  fam_q;
	logic [15:0] port_q;
	logic [31:0] fzo_q;
	logic        zs_q;
	logic        valid_q;

	// state after this word, used for the verdict
	logic        start;
	logic [2:0]  ctx_n;
	logic        ctx_ok_n;
	logic [2:0]  step_n;
	logic [1:0]  fam_n;
	logic [15:0] port_n;
	logic [31:0] fzo_n;
	logic        zs_n;
	logic        lz;
	logic [3:0]  err;
	logic [3:0]  cx;
	result_t     r;

	assign pop = in_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_comb begin
		// a frame starts at its command word or, when that word is not queued, its first payload word
		start = work.first || (work.has && work.pos == '0);
		ctx_n = start ? 3'd0 : ctx_q;
		ctx_ok_n = start ? 1'b0 : ctx_ok_q;
		step_n = start ? CS_HOST : step_q;
		fam_n = start ? 2'd0 : fam_q;
		port_n = start ? 16'd0 : port_q;
		fzo_n = start ? 32'd0 : fzo_q;
		zs_n = start ? 1'b0 : zs_q;
		lz = (work.data == 8'd0);
		cx = decode_context(work.data);
		if (work.has) begin
			if (work.cmd == CMD_MACRO && work.pos == '0) begin
				ctx_ok_n = cx[3];
				ctx_n = cx[2:0];
			end
			if (work.cmd == CMD_CONNECT) begin
				unique case (step_n)
					CS_HOST: if (lz) step_n = CS_FAMILY;
					CS_FAMILY: begin
						if (work.data == 8'h55) begin
							step_n = CS_UNIX;
						end else begin
							step_n = CS_PORTHI;
							fam_n = (work.data == 8'h4C) ? 2'd0 :
								(work.data == 8'h34) ? 2'd1 :
								(work.data == 8'h36) ? 2'd2 : 2'd3;
						end
					end
					CS_PORTHI: begin
						port_n = {work.data, 8'd0};
						step_n = CS_PORTLO;
					end
					CS_PORTLO: begin
						port_n = {port_n[15:8], work.data};
						step_n = CS_AFTER;
					end
					CS_AFTER: step_n = CS_DONE;
					default: ;
				endcase
			end
			if (lz && !zs_n) begin
				zs_n = 1'b1;
				fzo_n = 32'(work.pos);
			end
		end

		// rule check for the frame's verdict
		unique case (work.cmd)
			CMD_OPTIONS, CMD_BODY, CMD_EOM: err = ERR_NONE;
			CMD_MACRO: err = ctx_ok_n ? ERR_NONE : ERR_CONTEXT;
			CMD_CONNECT: begin
				if (step_n == CS_HOST) err = ERR_HOST;
				else if (step_n == CS_UNIX) err = ERR_FAMILY;
				else if (step_n != CS_DONE) err = ERR_PORT;
				else if (!lz) err = ERR_NO_TERM;
				else if (fam_n == 2'd3) err = ERR_FAMILY;
				else err = ERR_NONE;
			end
			CMD_HELO, CMD_MAIL, CMD_RCPT:
				err = lz ? ERR_NONE : ERR_HELO + (work.cmd - CMD_HELO);
			CMD_HEADER: err = (zs_n && lz) ? ERR_NONE : ERR_HEADER;
			CMD_EOH, CMD_ABORT, CMD_QUIT: err = work.len_one ? ERR_NONE : ERR_TOO_LONG;
			default: err = ERR_UNKNOWN;
		endcase

		r = '0;
		if (work.ended) begin
			r.kind = EV_ENDED;
		end else if (work.refused) begin
			r.kind = EV_REFUSED;
			r.err = work.ref_err;
		end else if (work.zero_len) begin
			r.kind = EV_REJECT;
			r.cmd = CMD_UNKNOWN;
			r.err = ERR_ZERO_LEN;
		end else begin
			r.has = work.has;
			r.data = work.has ? work.data : 8'd0;
			r.cmd = work.cmd;
			if (!work.last) begin
				r.kind = EV_BYTE;
			end else if (err != ERR_NONE) begin
				r.kind = EV_REJECT;
				r.err = err;
			end else begin
				r.kind = EV_ACCEPT;
				r.ctx = (work.cmd == CMD_MACRO) ? ctx_n : 3'd0;
				r.fam = (work.cmd == CMD_CONNECT) ? fam_n : 2'd0;
				r.port = (work.cmd == CMD_CONNECT) ? port_n : 16'd0;
				r.nlen = (work.cmd == CMD_HEADER) ? fzo_n : 32'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctx_q <= '0;
			ctx_ok_q <= 1'b0;
			step_q <= CS_HOST;
			fam_q <= '0;
			port_q <= '0;
			fzo_q <= '0;
			zs_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				ctx_q <= ctx_n;
				ctx_ok_q <= ctx_ok_n;
				step_q <= step_n;
				fam_q <= fam_n;
				port_q <= port_n;
				fzo_q <= fzo_n;
				zs_q <= zs_n;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= r;
	end
endmodule

@@ sv/lpcd_verdict.sv @@
// Early reject prediction so the front can lock without waiting for the back
`timescale 1ns / 1ps
module lpcd_verdict (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  lpcd_pkg::work_t work,
	output logic            reject
);
	import lpcd_pkg::*;

	// tracking of the frame rules on the accepted side
	logic [2:0] step_q;
	logic       fam_bad_q;
	logic       ctx_ok_q;
	logic       zs_q;
	logic [2:0] step_n;
	logic       fam_bad_n;
	logic       ctx_ok_n;
	logic       zs_n;
	logic       lz;
	logic [3:0] cx;

	always_comb begin
		step_n = work.first ? CS_HOST : step_q;
		fam_bad_n = work.first ? 1'b0 : fam_bad_q;
		ctx_ok_n = work.first ? 1'b0 : ctx_ok_q;
		zs_n = work.first ? 1'b0 : zs_q;
		lz = (work.data == 8'd0);
		cx = decode_context(work.data);
		if (work.has) begin
			if (work.cmd == CMD_MACRO && work.pos == '0) ctx_ok_n = cx[3];
			if (work.cmd == CMD_CONNECT) begin
				unique case (step_q)
					CS_HOST: if (lz) step_n = CS_FAMILY;
					CS_FAMILY: begin
						if (work.data == 8'h55) begin
							step_n = CS_UNIX;
						end else begin
							step_n = CS_PORTHI;
							fam_bad_n = !(work.data == 8'h4C || work.data == 8'h34
								|| work.data == 8'h36);
						end
					end
					CS_PORTHI: step_n = CS_PORTLO;
					CS_PORTLO: step_n = CS_AFTER;
					CS_AFTER: step_n = CS_DONE;
					default: ;
				endcase
			end
			if (lz) zs_n = 1'b1;
		end
		unique case (work.cmd)
			CMD_OPTIONS, CMD_BODY, CMD_EOM: reject = 1'b0;
			CMD_MACRO: reject = !ctx_ok_n;
			CMD_CONNECT: reject = step_n != CS_DONE || !lz || fam_bad_n;
			CMD_HELO, CMD_MAIL, CMD_RCPT: reject = !lz;
			CMD_HEADER: reject = !(zs_n && lz);
			CMD_EOH, CMD_ABORT, CMD_QUIT: reject = !work.len_one;
			default: reject = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= CS_HOST;
			fam_bad_q <= 1'b0;
			ctx_ok_q <= 1'b0;
			zs_q <= 1'b0;
		end else if (acc && (work.first || work.has)) begin
			step_q <= step_n;
			fam_bad_q <= fam_bad_n;
			ctx_ok_q <= ctx_ok_n;
			zs_q <= zs_n;
		end
	end
endmodule

@@ sv/length_prefixed_command_deframer_unit.sv @@
// Top level of the length-prefixed command deframer
`timescale 1ns / 1ps
// Takes one stream word per cycle while the queue has room and gives at most one
// result per word. A front end collects the length prefix and frames commands; a
// rule tracker beside it decides a rejection on the frame's last word so the front
// locks at once; a two-entry queue feeds the back end, which checks the command
// rules and holds the result in an output register. Sustained rate is one word per
// cycle, set by the front taking a word every cycle while the queue has room. When
// the output is free, an accepted word enters the queue at its accepting edge and
// the back then registers its result in the output register. Prefix words, but for
// the last prefix word of a zero length, and the command word of a longer frame
// give no result and skip the queue. When the output is held, the queue and the
// output register absorb three results before the input is held off.
module length_prefixed_command_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic        has_byte,
	output logic [7:0]  payload_byte,
	output logic [3:0]  command_code,
	output logic [2:0]  macro_scope,
	output logic [1:0]  address_family,
	output logic [15:0] port_number,
	output logic [31:0] name_length,
	output logic [3:0]  error_code
);
	import lpcd_pkg::*;

	work_t   work_f;
	work_t   work_b;
	result_t res;
	logic    push;
	logic    full;
	logic    q_valid;
	logic    pop;
	logic    reject;

	lpcd_front u_front (
		.clk, .arst_n, .valid(in_valid), .ready(in_ready), .data_byte, .end_stream,
		.push, .full, .verdict_reject(reject), .work(work_f)
	);

	lpcd_verdict u_verdict (
		.clk, .arst_n, .acc(in_valid && in_ready && !end_stream), .work(work_f),
		.reject
	);

	lpcd_queue u_queue (
		.clk, .arst_n, .push, .din(work_f), .full, .pop_valid(q_valid), .pop,
		.dout(work_b)
	);

	lpcd_back u_back (
		.clk, .arst_n, .in_valid(q_valid), .pop, .work(work_b),
		.out_valid, .out_ready, .res_q(res)
	);

	assign event_kind = res.kind;
	assign has_byte = res.has;
	assign payload_byte = res.data;
	assign command_code = res.cmd;
	assign macro_scope = res.ctx;
	assign address_family = res.fam;
	assign port_number = res.port;
	assign name_length = res.nlen;
	assign error_code = res.err;

	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");

	// a payload word carries no error
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_BYTE |-> error_code == ERR_NONE && has_byte)
		else $error("payload word with error");

	// accepted verdicts carry no error
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_ACCEPT |-> error_code == ERR_NONE)
		else $error("accepted frame with error");
endmodule
